### design/mop_pkg.sv
`default_nettype none
package mop_pkg;

	// Field widths fixed by the interface.
	localparam int POS_W   = 16;
	localparam int DMG_W   = 8;
	localparam int OWN_W   = 2;
	localparam int KIND_W  = 4;
	localparam int SLOT_W  = 4;
	localparam int FUNC_W  = 2;
	localparam int EV_W    = 3;
	localparam int SCR_W   = 15;
	localparam int SPR_W   = 8;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	// Command codes carried in the input tuser.
	localparam logic [FUNC_W-1:0] FN_SPAWN   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_TICK    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

	// Configuration register indexes (byte address is 4 times the index).
	localparam logic [1:0] REG_SCREEN_RIGHT  = 2'd0;
	localparam logic [1:0] REG_SCREEN_BOTTOM = 2'd1;
	localparam logic [1:0] REG_SPRITE_WIDTH  = 2'd2;
	localparam logic [1:0] REG_SPRITE_HEIGHT = 2'd3;

	localparam logic [SCR_W-1:0] RST_SCREEN_RIGHT  = 15'd320;
	localparam logic [SCR_W-1:0] RST_SCREEN_BOTTOM = 15'd224;
	localparam logic [SPR_W-1:0] RST_SPRITE_WIDTH  = 8'd8;
	localparam logic [SPR_W-1:0] RST_SPRITE_HEIGHT = 8'd8;

	typedef enum logic [EV_W-1:0] {
		EV_SPAWNED  = 3'd0,
		EV_FULL     = 3'd1,
		EV_MOVED    = 3'd2,
		EV_RELEASED = 3'd3,
		EV_DONE     = 3'd4
	} event_t;

	// Where the payload of an emitted result comes from.
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_CMD,
		SRC_SUM,
		SRC_RAM
	} src_t;

	// One stored object; x sits in the low bits, matching the request tdata.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OWN_W-1:0]  owner;
		logic [DMG_W-1:0]  damage;
		logic [POS_W-1:0]  vy;
		logic [POS_W-1:0]  vx;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  x;
	} obj_t;

	// One result payload, slot in the low bits.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OWN_W-1:0]  owner;
		logic [DMG_W-1:0]  damage;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  x;
		logic [SLOT_W-1:0] slot;
	} res_t;

	typedef struct packed {
		logic [SCR_W-1:0] screen_right;
		logic [SCR_W-1:0] screen_bottom;
		logic [SPR_W-1:0] sprite_width;
		logic [SPR_W-1:0] sprite_height;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic   load;
		logic   idx_clr;
		logic   idx_inc;
		logic   rd;
		logic   sum_ld;
		logic   spawn_wr;
		logic   move_wr;
		logic   act_set;
		logic   act_clr;
		logic   emit;
		event_t ev;
		src_t   src;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              active_cur;
		logic              idx_last;
		logic              out_free;
		logic              outside;
	} sts_t;

endpackage
`default_nettype wire

### design/mop_ram.sv
`default_nettype none
module mop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### design/mop_cfg.sv
`default_nettype none
module mop_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output mop_pkg::cfg_t    cfg
);
	import mop_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_right  <= RST_SCREEN_RIGHT;
			cfg_q.screen_bottom <= RST_SCREEN_BOTTOM;
			cfg_q.sprite_width  <= RST_SPRITE_WIDTH;
			cfg_q.sprite_height <= RST_SPRITE_HEIGHT;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SCREEN_RIGHT:  cfg_q.screen_right  <= pwdata[SCR_W-1:0];
				REG_SCREEN_BOTTOM: cfg_q.screen_bottom <= pwdata[SCR_W-1:0];
				REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= pwdata[SPR_W-1:0];
				REG_SPRITE_HEIGHT: cfg_q.sprite_height <= pwdata[SPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_SCREEN_RIGHT:  prdata = 32'(cfg_q.screen_right);
			REG_SCREEN_BOTTOM: prdata = 32'(cfg_q.screen_bottom);
			REG_SPRITE_WIDTH:  prdata = 32'(cfg_q.sprite_width);
			REG_SPRITE_HEIGHT: prdata = 32'(cfg_q.sprite_height);
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### design/mop_dp.sv
`default_nettype none
module mop_dp #(
	parameter int POOL_SLOTS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mop_pkg::cfg_t                      cfg,
	input  wire mop_pkg::cmd_t                      cmd,
	output mop_pkg::sts_t                           sts,
	input  wire logic [mop_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  wire logic [mop_pkg::FUNC_W-1:0]         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic      [mop_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic      [mop_pkg::EV_W-1:0]           m_axis_tuser,
	output logic                                    m_axis_tlast
);
	import mop_pkg::*;

	localparam int IW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int OBJ_W = $bits(obj_t);

	// Request capture.
	obj_t              req_q;
	logic [FUNC_W-1:0] func_q;

	logic [IW-1:0]         idx_q;
	logic [POOL_SLOTS-1:0] active_q;
	logic [POS_W-1:0]      sum_x_q;
	logic [POS_W-1:0]      sum_y_q;

	obj_t       rd_obj;
	logic [OBJ_W-1:0] rd_raw;
	obj_t       wr_obj;
	logic       ram_we;

	logic                  m_valid_q;
	res_t                  m_res_q;
	event_t                m_ev_q;
	res_t                  res_d;

	logic signed [POS_W:0] x_ext;
	logic signed [POS_W:0] y_ext;
	logic signed [POS_W:0] x_lo;
	logic signed [POS_W:0] y_lo;
	logic signed [POS_W:0] x_hi;
	logic signed [POS_W:0] y_hi;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= obj_t'(s_axis_tdata[OBJ_W-1:0]);
			func_q <= s_axis_tuser;
		end
		if (cmd.sum_ld) begin
			sum_x_q <= rd_obj.x + rd_obj.vx;
			sum_y_q <= rd_obj.y + rd_obj.vy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.act_set) begin
				active_q[idx_q] <= 1'b1;
			end else if (cmd.act_clr) begin
				active_q[idx_q] <= 1'b0;
			end
		end
	end

	// Object store: one write port for spawn and motion write-back, one read port.
	assign ram_we = cmd.spawn_wr || cmd.move_wr;
	assign rd_obj = obj_t'(rd_raw);

	always_comb begin
		wr_obj = rd_obj;
		if (cmd.spawn_wr) begin
			wr_obj = req_q;
		end else begin
			wr_obj.x = sum_x_q;
			wr_obj.y = sum_y_q;
		end
	end

	mop_ram #(
		.WIDTH(OBJ_W),
		.DEPTH(POOL_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_obj),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(rd_raw)
	);

	// Window test on the freshly summed position; a bound itself is on screen.
	always_comb begin
		x_ext = $signed({sum_x_q[POS_W-1], sum_x_q});
		y_ext = $signed({sum_y_q[POS_W-1], sum_y_q});
		x_lo  = -$signed({1'b0, POS_W'(cfg.sprite_width)});
		y_lo  = -$signed({1'b0, POS_W'(cfg.sprite_height)});
		x_hi  = $signed({2'b00, cfg.screen_right});
		y_hi  = $signed({2'b00, cfg.screen_bottom});
	end

	// Result payload selection.
	always_comb begin
		res_d = '0;
		unique case (cmd.src)
			SRC_ZERO: res_d = '0;
			SRC_CMD: begin
				res_d.slot   = SLOT_W'(idx_q);
				res_d.x      = req_q.x;
				res_d.y      = req_q.y;
				res_d.damage = req_q.damage;
				res_d.owner  = req_q.owner;
				res_d.kind   = req_q.kind;
			end
			SRC_SUM: begin
				res_d.slot   = SLOT_W'(idx_q);
				res_d.x      = sum_x_q;
				res_d.y      = sum_y_q;
				res_d.damage = rd_obj.damage;
				res_d.owner  = rd_obj.owner;
				res_d.kind   = rd_obj.kind;
			end
			SRC_RAM: begin
				res_d.slot   = SLOT_W'(idx_q);
				res_d.x      = rd_obj.x;
				res_d.y      = rd_obj.y;
				res_d.damage = rd_obj.damage;
				res_d.owner  = rd_obj.owner;
				res_d.kind   = rd_obj.kind;
			end
			default: res_d = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_res_q <= res_d;
			m_ev_q  <= cmd.ev;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(m_res_q);
	assign m_axis_tuser  = m_ev_q;
	assign m_axis_tlast  = (m_ev_q == EV_DONE);

	always_comb begin
		sts.func       = func_q;
		sts.active_cur = active_q[idx_q];
		sts.idx_last   = (idx_q == IW'(POOL_SLOTS - 1));
		sts.out_free   = !m_valid_q || m_axis_tready;
		sts.outside    = (x_ext < x_lo) || (x_ext > x_hi) ||
		                 (y_ext < y_lo) || (y_ext > y_hi);
	end

	// A spawn only ever claims a free slot.
	a_spawn_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.spawn_wr |-> !active_q[idx_q])
		else $error("spawn wrote into an active slot");

	// A claimed slot is active on the next cycle.
	a_set_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act_set && !cmd.idx_inc && !cmd.idx_clr) |=> active_q[idx_q])
		else $error("slot claim was lost");

endmodule
`default_nettype wire

### design/mop_ctrl.sv
`default_nettype none
module mop_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire mop_pkg::sts_t  sts,
	output mop_pkg::cmd_t       cmd
);
	import mop_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_SCAN,
		S_SEL,
		S_CALC,
		S_WB,
		S_REL,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.ev        = EV_DONE;
		cmd.src       = SRC_ZERO;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.func == FN_SPAWN) begin
					state_d = S_SCAN;
				end else if (sts.func == FN_TICK || sts.func == FN_RELEASE) begin
					state_d = S_SEL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				priority if (!sts.active_cur) begin
					if (sts.out_free) begin
						cmd.spawn_wr = 1'b1;
						cmd.act_set  = 1'b1;
						cmd.emit     = 1'b1;
						cmd.ev       = EV_SPAWNED;
						cmd.src      = SRC_CMD;
						state_d      = S_DONE;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.ev   = EV_FULL;
						cmd.src  = SRC_ZERO;
						state_d  = S_DONE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SEL: begin
				priority if (sts.active_cur) begin
					cmd.rd  = 1'b1;
					state_d = (sts.func == FN_TICK) ? S_CALC : S_REL;
				end else if (sts.idx_last) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_CALC: begin
				cmd.sum_ld = 1'b1;
				state_d    = S_WB;
			end
			S_WB: begin
				if (sts.out_free) begin
					cmd.move_wr = 1'b1;
					cmd.act_clr = sts.outside;
					cmd.emit    = 1'b1;
					cmd.ev      = sts.outside ? EV_RELEASED : EV_MOVED;
					cmd.src     = SRC_SUM;
					cmd.idx_inc = !sts.idx_last;
					state_d     = sts.idx_last ? S_DONE : S_SEL;
				end
			end
			S_REL: begin
				if (sts.out_free) begin
					cmd.act_clr = 1'b1;
					cmd.emit    = 1'b1;
					cmd.ev      = EV_RELEASED;
					cmd.src     = SRC_RAM;
					cmd.idx_inc = !sts.idx_last;
					state_d     = sts.idx_last ? S_DONE : S_SEL;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.ev   = EV_DONE;
					cmd.src  = SRC_ZERO;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// A result is only loaded when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwrote a pending result");

	// The done result closes every command and the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.ev == EV_DONE) |=> state_q == S_IDLE)
		else $error("done result did not end the command");

	// The slot walk never steps past the last slot.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idx_inc |-> !sts.idx_last)
		else $error("slot index stepped past the pool");

endmodule
`default_nettype wire

### design/moving_object_pool.sv
// Sequence: a request is taken in idle and goes through dispatch; spawn then scans the slots
//   up to the first free one (all of them when full), tick visits each slot and reads, sums
//   and writes back each active one, and release-all reads and frees each active slot.
//   The done result follows the last slot result; no new request is taken until it is loaded.
// Reset: arst_n clears the pool (all slots free), the controller and the output valid.
`default_nettype none
module moving_object_pool #(
	parameter int POOL_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Request stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] start_x, [31:16] start_y, [47:32] speed_x, [63:48] speed_y,
	// [71:64] hit_damage, [73:72] owner_tag, [77:74] kind_tag, [79:78] zero
	input  wire logic [mop_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] func
	input  wire logic [mop_pkg::FUNC_W-1:0]     s_axis_tuser,

	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [3:0] slot, [19:4] pos_x, [35:20] pos_y, [43:36] obj_damage,
	// [45:44] obj_owner, [49:46] obj_kind, [55:50] zero
	output logic [mop_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// [2:0] event_res
	output logic [mop_pkg::EV_W-1:0]            m_axis_tuser,
	// last
	output logic             m_axis_tlast,

	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import mop_pkg::*;

	// The configuration block holds the screen window and sprite margins, which the datapath
	// reads directly; the user must change them only while no request is in flight (not enforced).
	cfg_t cfg;
	// The controller walks the slots and issues one command word per cycle; the
	// datapath answers with a status word about the current slot and the output side.
	cmd_t cmd;
	sts_t sts;

	mop_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The controller accepts a request only from idle. Spawn scans for the first free
	// slot; tick reads each active slot, sums velocity into position in a registered
	// step, then tests the window and writes back; release-all reads and frees each
	// active slot. Every emit waits until the output register is empty or being taken.
	mop_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// The datapath owns the request register, the slot index, the active bits, the
	// object memory, the motion adders with the window compare and the output register.
	mop_dp #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire
